>>> rtl/core/kpwq_pkg.sv
package kpwq_pkg;

  localparam int WORKERS_DEF     = 4;
  localparam int QUEUE_SLOTS_DEF = 32;
  localparam int OWNER_W         = 4;

  localparam logic [5:0] CAP_RESET = 6'd32;

  // register index taken from paddr[2]
  localparam logic CFG_CAP = 1'b0;

  localparam logic [2:0] ACT_SUBMIT   = 3'd0;
  localparam logic [2:0] ACT_CANCEL   = 3'd1;
  localparam logic [2:0] ACT_DEQUEUE  = 3'd2;
  localparam logic [2:0] ACT_COMPLETE = 3'd3;
  localparam logic [2:0] ACT_SHUTDOWN = 3'd4;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_STALE    = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_CANCEL   = 3'd3;
  localparam logic [2:0] ST_DISPATCH = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  typedef struct packed {
    logic [2:0]         action;
    logic [31:0]        key;
    logic signed [31:0] version;
    logic               priority_req;
    logic [15:0]        task_tag;
    logic [1:0]         worker;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] tag_out;
    logic [31:0] key_out;
    logic [1:0]  worker_out;
    logic        last;
  } out_t;

  typedef struct packed {
    in_t                item;
    logic [OWNER_W-1:0] owner;
  } cmd_t;

endpackage

>>> rtl/core/kpwq_fifo.sv
module kpwq_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  logic [DW-1:0] wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] rdata_o,
  output logic          empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [DW-1:0]   mem_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CNTW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign full_o  = (cnt_r == CNTW'(DEPTH));
  assign empty_o = (cnt_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/kpwq_front.sv
module kpwq_front #(
  parameter int WORKERS = kpwq_pkg::WORKERS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_i,
  input  kpwq_pkg::in_t   item_i,
  output logic            full_o,
  input  logic            cmd_full_i,
  output logic            cmd_push_o,
  output kpwq_pkg::cmd_t  cmd_o
);

  localparam int RW = $clog2(WORKERS + 1);
  localparam logic [63:0] FNV_OFFSET = 64'hCBF29CE484222325;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_HASH = 4'b0010,
    F_MOD  = 4'b0100,
    F_OUT  = 4'b1000
  } fstate_t;

  fstate_t        st_r, st_nxt;
  kpwq_pkg::in_t  item_r, item_nxt;
  logic [63:0]    hash_r, hash_nxt;
  logic [1:0]     rnd_r, rnd_nxt;
  logic [3:0]     cnt_r, cnt_nxt;
  logic [RW-1:0]  md_r, md_nxt;

  // prime is 2^40 + 0x1b3, so the product is a handful of shifted adds
  function automatic logic [63:0] fnv_round(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  // four bits of restoring remainder, msb first
  function automatic logic [RW-1:0] mod_nib(input logic [RW-1:0] r, input logic [3:0] nib);
    logic [RW:0]   v;
    logic [RW-1:0] acc;
    acc = r;
    for (int k = 3; k >= 0; k--) begin
      v = {acc, nib[k]};
      if (v >= (RW+1)'(WORKERS)) begin
        v = v - (RW+1)'(WORKERS);
      end
      acc = v[RW-1:0];
    end
    return acc;
  endfunction

  assign full_o     = (st_r != F_IDLE);
  assign cmd_push_o = (st_r == F_OUT) && !cmd_full_i;
  assign cmd_o      = '{item: item_r, owner: kpwq_pkg::OWNER_W'(md_r)};

  always_comb begin
    st_nxt   = st_r;
    item_nxt = item_r;
    hash_nxt = hash_r;
    rnd_nxt  = rnd_r;
    cnt_nxt  = cnt_r;
    md_nxt   = md_r;
    unique case (st_r)
      F_IDLE: begin
        if (push_i) begin
          item_nxt = item_i;
          hash_nxt = FNV_OFFSET;
          rnd_nxt  = '0;
          cnt_nxt  = 4'hF;
          md_nxt   = '0;
          if (item_i.action == kpwq_pkg::ACT_SUBMIT ||
              item_i.action == kpwq_pkg::ACT_CANCEL) begin
            st_nxt = F_HASH;
          end else begin
            st_nxt = F_OUT;
          end
        end
      end
      F_HASH: begin
        hash_nxt = fnv_round(hash_r, item_r.key[rnd_r*8 +: 8]);
        rnd_nxt  = rnd_r + 1'b1;
        if (rnd_r == 2'd3) begin
          st_nxt = F_MOD;
        end
      end
      F_MOD: begin
        md_nxt  = mod_nib(md_r, hash_r[cnt_r*4 +: 4]);
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 4'd0) begin
          st_nxt = F_OUT;
        end
      end
      F_OUT: begin
        if (!cmd_full_i) begin
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    hash_r <= hash_nxt;
    rnd_r  <= rnd_nxt;
    cnt_r  <= cnt_nxt;
    md_r   <= md_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

>>> rtl/core/kpwq_back.sv
module kpwq_back #(
  parameter int WORKERS     = kpwq_pkg::WORKERS_DEF,
  parameter int QUEUE_SLOTS = kpwq_pkg::QUEUE_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [5:0]     cap_i,
  input  kpwq_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output kpwq_pkg::out_t res_o
);

  localparam int REGION = QUEUE_SLOTS / WORKERS;
  localparam int AW     = $clog2(QUEUE_SLOTS);
  localparam int LW     = $clog2(REGION + 1);
  localparam int WW     = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int CW     = 14;

  typedef struct packed {
    logic [15:0]        tag;
    logic [31:0]        key;
    logic signed [31:0] ver;
    logic               bg;
  } slot_t;

  typedef enum logic [21:0] {
    S_IDLE     = 22'b1 << 0,
    S_START    = 22'b1 << 1,
    S_SCAN_RD  = 22'b1 << 2,
    S_SCAN_CHK = 22'b1 << 3,
    S_SUB_DEC  = 22'b1 << 4,
    S_RESCAN   = 22'b1 << 5,
    S_CO2      = 22'b1 << 6,
    S_CO3      = 22'b1 << 7,
    S_ACC2     = 22'b1 << 8,
    S_INS_RD   = 22'b1 << 9,
    S_INS_WR   = 22'b1 << 10,
    S_RM_RD    = 22'b1 << 11,
    S_RM_WR    = 22'b1 << 12,
    S_CAN_RD   = 22'b1 << 13,
    S_CAN_CHK  = 22'b1 << 14,
    S_CAN_RUN  = 22'b1 << 15,
    S_DEQ_CHK  = 22'b1 << 16,
    S_SD_RD    = 22'b1 << 17,
    S_SD_CHK   = 22'b1 << 18,
    S_SD_RUN   = 22'b1 << 19,
    S_FIN      = 22'b1 << 20,
    S_SPARE    = 22'b1 << 21
  } bstate_t;

  // slot memory
  slot_t          mem [QUEUE_SLOTS];
  slot_t          rdata_r;
  logic           re, we;
  logic [AW-1:0]  raddr, waddr;
  slot_t          wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  bstate_t            state_r, state_nxt, ret_r, ret_nxt;
  logic [2:0]         op_r, op_nxt;
  logic [31:0]        key_r, key_nxt;
  logic signed [31:0] ver_r, ver_nxt;
  logic               bg_r, bg_nxt;
  logic [15:0]        tag_r, tag_nxt;
  logic [1:0]         wk_r, wk_nxt;
  logic [WW-1:0]      w_r, w_nxt;
  logic [LW-1:0]      i_r, i_nxt, m_r, m_nxt, pos_r, pos_nxt;
  logic [LW-1:0]      jm_r, jm_nxt, jb_r, jb_nxt;
  logic               jm_f_r, jm_f_nxt, jb_f_r, jb_f_nxt, evicted_r, evicted_nxt;
  logic [15:0]        jm_tag_r, jm_tag_nxt, jb_tag_r, jb_tag_nxt;
  logic signed [31:0] jm_ver_r, jm_ver_nxt;
  logic [31:0]        jb_key_r, jb_key_nxt;
  logic               acc_r, acc_nxt;
  logic [LW-1:0]      len_r [WORKERS];
  logic [LW-1:0]      len_nxt [WORKERS];
  logic               rv_r [WORKERS];
  logic               rv_nxt [WORKERS];
  logic [31:0]        rk_r [WORKERS];
  logic [31:0]        rk_nxt [WORKERS];
  logic [15:0]        rt_r [WORKERS];
  logic [15:0]        rt_nxt [WORKERS];
  kpwq_pkg::out_t     held_r, held_nxt;
  logic               held_v_r, held_v_nxt;

  logic               em_v;
  kpwq_pkg::out_t     em_d;
  logic               can_emit, run_match, wk_bad, q_full;
  logic [LW-1:0]      cur_len;
  logic [CW-1:0]      cap_c;

  function automatic logic [AW-1:0] addr_of(input logic [WW-1:0] w, input logic [LW-1:0] i);
    return AW'((AW+1)'(w) * (AW+1)'(REGION)) + AW'(i);
  endfunction

  function automatic kpwq_pkg::out_t mk(input logic [2:0] st, input logic [15:0] tg,
                                        input logic [31:0] ky, input logic [1:0] wo);
    return '{status: st, tag_out: tg, key_out: ky, worker_out: wo, last: 1'b0};
  endfunction

  assign cur_len   = len_r[w_r];
  assign run_match = rv_r[w_r] && (rk_r[w_r] == key_r);
  assign wk_bad    = ({3'b000, wk_r} >= 5'(WORKERS));
  assign can_emit  = !held_v_r || !res_full_i;
  assign cap_c     = (CW'(cap_i) < CW'(WORKERS)) ? CW'(WORKERS) :
                     (CW'(cap_i) > CW'(QUEUE_SLOTS)) ? CW'(QUEUE_SLOTS) : CW'(cap_i);
  // len >= share(w) without dividing: share is the count of t < cap with t mod W == w
  assign q_full    = (CW'(cur_len) * CW'(WORKERS) + CW'(w_r) >= cap_c) ||
                     (cur_len >= LW'(REGION));

  // one result is held back so the final one can be marked last
  assign res_push_o = (em_v && held_v_r) || (state_r == S_FIN && held_v_r && !res_full_i);
  always_comb begin
    res_o      = held_r;
    res_o.last = (state_r == S_FIN);
  end

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    ver_nxt     = ver_r;
    bg_nxt      = bg_r;
    tag_nxt     = tag_r;
    wk_nxt      = wk_r;
    w_nxt       = w_r;
    i_nxt       = i_r;
    m_nxt       = m_r;
    pos_nxt     = pos_r;
    jm_nxt      = jm_r;
    jb_nxt      = jb_r;
    jm_f_nxt    = jm_f_r;
    jb_f_nxt    = jb_f_r;
    evicted_nxt = evicted_r;
    jm_tag_nxt  = jm_tag_r;
    jm_ver_nxt  = jm_ver_r;
    jb_tag_nxt  = jb_tag_r;
    jb_key_nxt  = jb_key_r;
    acc_nxt     = acc_r;
    len_nxt     = len_r;
    rv_nxt      = rv_r;
    rk_nxt      = rk_r;
    rt_nxt      = rt_r;
    cmd_pop_o   = 1'b0;
    re          = 1'b0;
    raddr       = '0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    em_v        = 1'b0;
    em_d        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          op_nxt    = cmd_i.item.action;
          key_nxt   = cmd_i.item.key;
          ver_nxt   = cmd_i.item.version;
          bg_nxt    = cmd_i.item.priority_req;
          tag_nxt   = cmd_i.item.task_tag;
          wk_nxt    = cmd_i.item.worker;
          if (cmd_i.item.action == kpwq_pkg::ACT_SUBMIT ||
              cmd_i.item.action == kpwq_pkg::ACT_CANCEL) begin
            w_nxt = WW'(cmd_i.owner);
          end else begin
            w_nxt = WW'(cmd_i.item.worker);
          end
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (can_emit) begin
          i_nxt       = '0;
          jm_f_nxt    = 1'b0;
          jb_f_nxt    = 1'b0;
          evicted_nxt = 1'b0;
          state_nxt   = S_FIN;
          case (op_r)
            kpwq_pkg::ACT_SUBMIT: begin
              if (!acc_r) begin
                em_v = 1'b1;
                em_d = mk(kpwq_pkg::ST_REJECTED, tag_r, key_r, 2'(w_r));
              end else begin
                state_nxt = S_SCAN_RD;
              end
            end
            kpwq_pkg::ACT_CANCEL: state_nxt = S_CAN_RD;
            kpwq_pkg::ACT_DEQUEUE: begin
              if (wk_bad || cur_len == '0) begin
                em_v = 1'b1;
                em_d = mk(kpwq_pkg::ST_EMPTY, 16'd0, 32'd0, wk_r);
              end else begin
                re        = 1'b1;
                raddr     = addr_of(w_r, '0);
                state_nxt = S_DEQ_CHK;
              end
            end
            kpwq_pkg::ACT_COMPLETE: begin
              em_v = 1'b1;
              if (wk_bad || !rv_r[w_r]) begin
                em_d = mk(kpwq_pkg::ST_EMPTY, 16'd0, 32'd0, wk_r);
              end else begin
                rv_nxt[w_r] = 1'b0;
                em_d = mk(kpwq_pkg::ST_DONE, rt_r[w_r], rk_r[w_r], wk_r);
              end
            end
            kpwq_pkg::ACT_SHUTDOWN: begin
              if (acc_r) begin
                acc_nxt   = 1'b0;
                w_nxt     = '0;
                state_nxt = S_SD_RD;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (i_r < cur_len) begin
          re        = 1'b1;
          raddr     = addr_of(w_r, i_r);
          state_nxt = S_SCAN_CHK;
        end else begin
          state_nxt = S_SUB_DEC;
        end
      end
      S_SCAN_CHK: begin
        if (rdata_r.bg) begin
          if (!jb_f_r) begin
            jb_f_nxt   = 1'b1;
            jb_nxt     = i_r;
            jb_tag_nxt = rdata_r.tag;
            jb_key_nxt = rdata_r.key;
          end
          if (!jm_f_r && rdata_r.key == key_r) begin
            jm_f_nxt   = 1'b1;
            jm_nxt     = i_r;
            jm_tag_nxt = rdata_r.tag;
            jm_ver_nxt = rdata_r.ver;
          end
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = S_SCAN_RD;
      end
      S_SUB_DEC: begin
        if (can_emit) begin
          em_v = 1'b1;
          if (bg_r && jm_f_r && !evicted_r) begin
            if (ver_r >= jm_ver_r) begin
              em_d      = mk(kpwq_pkg::ST_ACCEPTED, tag_r, key_r, 2'(w_r));
              state_nxt = S_CO2;
            end else begin
              em_d      = mk(kpwq_pkg::ST_STALE, tag_r, key_r, 2'(w_r));
              state_nxt = S_FIN;
            end
          end else if (!evicted_r && q_full) begin
            if (!jb_f_r) begin
              em_d      = mk(kpwq_pkg::ST_REJECTED, tag_r, key_r, 2'(w_r));
              state_nxt = S_FIN;
            end else begin
              // evict the first background task, then look again for placement
              em_d        = mk(kpwq_pkg::ST_CANCEL, jb_tag_r, jb_key_r, 2'(w_r));
              evicted_nxt = 1'b1;
              m_nxt       = jb_r;
              ret_nxt     = S_RESCAN;
              state_nxt   = S_RM_RD;
            end
          end else begin
            em_d      = mk(kpwq_pkg::ST_ACCEPTED, tag_r, key_r, 2'(w_r));
            state_nxt = S_ACC2;
          end
        end
      end
      S_RESCAN: begin
        i_nxt     = '0;
        jm_f_nxt  = 1'b0;
        jb_f_nxt  = 1'b0;
        state_nxt = S_SCAN_RD;
      end
      S_CO2: begin
        if (can_emit) begin
          if (run_match) begin
            em_v = 1'b1;
            em_d = mk(kpwq_pkg::ST_CANCEL, rt_r[w_r], key_r, 2'(w_r));
          end
          state_nxt = S_CO3;
        end
      end
      S_CO3: begin
        if (can_emit) begin
          em_v      = 1'b1;
          em_d      = mk(kpwq_pkg::ST_CANCEL, jm_tag_r, key_r, 2'(w_r));
          we        = 1'b1;
          waddr     = addr_of(w_r, jm_r);
          wdata     = '{tag: tag_r, key: key_r, ver: ver_r, bg: 1'b1};
          state_nxt = S_FIN;
        end
      end
      S_ACC2: begin
        if (can_emit) begin
          if (bg_r && run_match) begin
            em_v = 1'b1;
            em_d = mk(kpwq_pkg::ST_CANCEL, rt_r[w_r], key_r, 2'(w_r));
          end
          // interactive goes after a same-key background task, else before any
          if (bg_r) begin
            pos_nxt = cur_len;
          end else if (jm_f_r) begin
            pos_nxt = jm_r + 1'b1;
          end else if (jb_f_r) begin
            pos_nxt = jb_r;
          end else begin
            pos_nxt = cur_len;
          end
          m_nxt = cur_len;
          if (cur_len >= LW'(REGION)) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_INS_RD;
          end
        end
      end
      S_INS_RD: begin
        if (m_r > pos_r) begin
          re        = 1'b1;
          raddr     = addr_of(w_r, m_r - 1'b1);
          state_nxt = S_INS_WR;
        end else begin
          we           = 1'b1;
          waddr        = addr_of(w_r, pos_r);
          wdata        = '{tag: tag_r, key: key_r, ver: ver_r, bg: bg_r};
          len_nxt[w_r] = cur_len + 1'b1;
          state_nxt    = S_FIN;
        end
      end
      S_INS_WR: begin
        we        = 1'b1;
        waddr     = addr_of(w_r, m_r);
        wdata     = rdata_r;
        m_nxt     = m_r - 1'b1;
        state_nxt = S_INS_RD;
      end
      S_RM_RD: begin
        if ((m_r + 1'b1) < cur_len) begin
          re        = 1'b1;
          raddr     = addr_of(w_r, m_r + 1'b1);
          state_nxt = S_RM_WR;
        end else begin
          len_nxt[w_r] = cur_len - 1'b1;
          state_nxt    = ret_r;
        end
      end
      S_RM_WR: begin
        we        = 1'b1;
        waddr     = addr_of(w_r, m_r);
        wdata     = rdata_r;
        m_nxt     = m_r + 1'b1;
        state_nxt = S_RM_RD;
      end
      S_CAN_RD: begin
        if (i_r < cur_len) begin
          re        = 1'b1;
          raddr     = addr_of(w_r, i_r);
          state_nxt = S_CAN_CHK;
        end else begin
          state_nxt = S_CAN_RUN;
        end
      end
      S_CAN_CHK: begin
        if (can_emit) begin
          if (rdata_r.key == key_r) begin
            em_v      = 1'b1;
            em_d      = mk(kpwq_pkg::ST_CANCEL, rdata_r.tag, key_r, 2'(w_r));
            m_nxt     = i_r;
            ret_nxt   = S_CAN_RD;
            state_nxt = S_RM_RD;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_CAN_RD;
          end
        end
      end
      S_CAN_RUN: begin
        if (can_emit) begin
          if (run_match) begin
            em_v = 1'b1;
            em_d = mk(kpwq_pkg::ST_CANCEL, rt_r[w_r], key_r, 2'(w_r));
          end
          state_nxt = S_FIN;
        end
      end
      S_DEQ_CHK: begin
        if (can_emit) begin
          rv_nxt[w_r] = 1'b1;
          rk_nxt[w_r] = rdata_r.key;
          rt_nxt[w_r] = rdata_r.tag;
          em_v        = 1'b1;
          em_d        = mk(kpwq_pkg::ST_DISPATCH, rdata_r.tag, rdata_r.key, wk_r);
          m_nxt       = '0;
          ret_nxt     = S_FIN;
          state_nxt   = S_RM_RD;
        end
      end
      S_SD_RD: begin
        if (i_r < cur_len) begin
          re        = 1'b1;
          raddr     = addr_of(w_r, i_r);
          state_nxt = S_SD_CHK;
        end else begin
          len_nxt[w_r] = '0;
          state_nxt    = S_SD_RUN;
        end
      end
      S_SD_CHK: begin
        if (can_emit) begin
          em_v      = 1'b1;
          em_d      = mk(kpwq_pkg::ST_CANCEL, rdata_r.tag, rdata_r.key, 2'(w_r));
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SD_RD;
        end
      end
      S_SD_RUN: begin
        if (can_emit) begin
          if (rv_r[w_r]) begin
            em_v = 1'b1;
            em_d = mk(kpwq_pkg::ST_CANCEL, rt_r[w_r], rk_r[w_r], 2'(w_r));
          end
          if (w_r == WW'(WORKERS - 1)) begin
            state_nxt = S_FIN;
          end else begin
            w_nxt     = w_r + 1'b1;
            i_nxt     = '0;
            state_nxt = S_SD_RD;
          end
        end
      end
      S_FIN: begin
        if (!held_v_r || !res_full_i) begin
          state_nxt = S_IDLE;
        end
      end
      S_SPARE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    if (em_v) begin
      held_nxt   = em_d;
      held_v_nxt = 1'b1;
    end else if (state_r == S_FIN && !res_full_i) begin
      held_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ret_r     <= ret_nxt;
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    ver_r     <= ver_nxt;
    bg_r      <= bg_nxt;
    tag_r     <= tag_nxt;
    wk_r      <= wk_nxt;
    w_r       <= w_nxt;
    i_r       <= i_nxt;
    m_r       <= m_nxt;
    pos_r     <= pos_nxt;
    jm_r      <= jm_nxt;
    jb_r      <= jb_nxt;
    jm_f_r    <= jm_f_nxt;
    jb_f_r    <= jb_f_nxt;
    evicted_r <= evicted_nxt;
    jm_tag_r  <= jm_tag_nxt;
    jm_ver_r  <= jm_ver_nxt;
    jb_tag_r  <= jb_tag_nxt;
    jb_key_r  <= jb_key_nxt;
    rk_r      <= rk_nxt;
    rt_r      <= rt_nxt;
    held_r    <= held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      acc_r    <= 1'b1;
      held_v_r <= 1'b0;
      for (int k = 0; k < WORKERS; k++) begin
        len_r[k] <= '0;
        rv_r[k]  <= 1'b0;
      end
    end else begin
      state_r  <= state_nxt;
      acc_r    <= acc_nxt;
      held_v_r <= held_v_nxt;
      len_r    <= len_nxt;
      rv_r     <= rv_nxt;
    end
  end

endmodule

>>> rtl/core/keyed_priority_work_queue.sv
// submit and cancel pass through the front in 4 hash rounds and 16 remainder steps, then one
// hand-off; the back then reads or shifts its queue slots one at a time
// the front takes no new word until it has handed the last one on; the pace is set by the
// serial key remainder in the front and the slot memory in the back
// reset: synchronous, active low; clears queue lengths, running flags and the fifos,
// slot contents are left as they are
module keyed_priority_work_queue #(
  parameter int WORKERS     = kpwq_pkg::WORKERS_DEF,
  parameter int QUEUE_SLOTS = kpwq_pkg::QUEUE_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  kpwq_pkg::in_t  in_item,
  input  logic           pop,
  output logic           empty,
  output kpwq_pkg::out_t out_item,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int CMD_W = $bits(kpwq_pkg::cmd_t);
  localparam int RES_W = $bits(kpwq_pkg::out_t);

  logic [5:0]     cap_r;
  kpwq_pkg::cmd_t f_cmd, b_cmd;
  logic           f_push, c_full, c_empty, c_pop;
  logic           r_push, r_full;
  kpwq_pkg::out_t b_res;
  logic [CMD_W-1:0] c_rdata;
  logic [RES_W-1:0] r_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == kpwq_pkg::CFG_CAP) ? {26'd0, cap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= kpwq_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == kpwq_pkg::CFG_CAP) begin
      cap_r <= pwdata[5:0];
    end
  end

  kpwq_front #(.WORKERS(WORKERS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .item_i     (in_item),
    .full_o     (full),
    .cmd_full_i (c_full),
    .cmd_push_o (f_push),
    .cmd_o      (f_cmd)
  );

  kpwq_fifo #(.DW(CMD_W), .DEPTH(2)) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (f_push),
    .wdata_i (f_cmd),
    .full_o  (c_full),
    .pop_i   (c_pop),
    .rdata_o (c_rdata),
    .empty_o (c_empty)
  );

  assign b_cmd = c_rdata;

  kpwq_back #(.WORKERS(WORKERS), .QUEUE_SLOTS(QUEUE_SLOTS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cap_i       (cap_r),
    .cmd_i       (b_cmd),
    .cmd_empty_i (c_empty),
    .cmd_pop_o   (c_pop),
    .res_full_i  (r_full),
    .res_push_o  (r_push),
    .res_o       (b_res)
  );

  kpwq_fifo #(.DW(RES_W), .DEPTH(4)) u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (r_push),
    .wdata_i (b_res),
    .full_o  (r_full),
    .pop_i   (pop),
    .rdata_o (r_rdata),
    .empty_o (empty)
  );

  assign out_item = r_rdata;

endmodule

>>> rtl/core/kpwq_checker.sv
module kpwq_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           pop,
  input logic           empty,
  input kpwq_pkg::out_t out_item
);

  // nothing waits on the result side right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // an empty answer names no task
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.status == kpwq_pkg::ST_EMPTY) |->
      (out_item.tag_out == 16'd0 && out_item.key_out == 32'd0))
    else $error("empty result carries a tag or key");

  // dequeue and complete answer with a single word
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_item.status == kpwq_pkg::ST_EMPTY ||
                out_item.status == kpwq_pkg::ST_DISPATCH ||
                out_item.status == kpwq_pkg::ST_DONE)) |-> out_item.last)
    else $error("dequeue or complete word not marked last");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("stalled result word changed");

endmodule

bind keyed_priority_work_queue kpwq_checker u_chk (.*);
